### src/fbd_pkg.sv
// Shared constants and types for the page monochrome frame buffer draw block.
package fbd_pkg;

   localparam int DEF_MAX_COLUMNS = 128;
   localparam int DEF_MAX_PAGES   = 8;

   localparam int EFF_W_W = 9;
   localparam int EFF_P_W = 4;

   localparam logic [2:0] OP_CLEAR = 3'd0;
   localparam logic [2:0] OP_FILL  = 3'd1;
   localparam logic [2:0] OP_PIXEL = 3'd2;
   localparam logic [2:0] OP_RECT  = 3'd3;
   localparam logic [2:0] OP_IMAGE = 3'd4;
   localparam logic [2:0] OP_READ  = 3'd5;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   localparam logic [7:0] WIDTH_RESET  = 8'd128;
   localparam logic [6:0] HEIGHT_RESET = 7'd64;

   localparam logic [7:0] BYTE_ONES  = 8'hFF;
   localparam logic [7:0] BYTE_ZEROS = 8'h00;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] x_first;
      logic [7:0] x_last;
      logic [7:0] y_first;
      logic [7:0] y_last;
      logic [7:0] image_col;
      logic [2:0] image_page;
      logic [7:0] pixel_byte;
      logic       set_bits;
      logic       invert_byte;
      logic [7:0] page_sel;
   } req_type;

endpackage

### src/page_mono_framebuffer_draw.sv
// Top level of the page monochrome frame buffer draw block: registers, sequencer and store.
//
//   channel   ports                           beat taken when
//   command   start, busy, req_*              start high and busy low
//   result    rsp_strobe, rsp_status, rsp_*   rsp_strobe high (one cycle, no stall)
//   config    csr_valid, csr_ready, csr_*     csr_valid and csr_ready high
//
// From the accepting edge: a decode state, then for an image byte an image state, then a walk
// state per store byte touched and a finish state, then the result beat, in whose cycle a new
// command can be taken. A rejected command, an empty clear/fill and a clipped image byte give
// their result without the walk. One store read port sets one byte a cycle.
// After reset the store is swept to zero, one byte a cycle, all MAX_COLUMNS * MAX_PAGES bytes
// (1024 by default), with busy high. Results cannot be stalled.
module page_mono_framebuffer_draw #(
   parameter int MAX_COLUMNS = fbd_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_PAGES   = fbd_pkg::DEF_MAX_PAGES
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_op,
   input  logic [7:0] req_x_first,
   input  logic [7:0] req_x_last,
   input  logic [7:0] req_y_first,
   input  logic [7:0] req_y_last,
   input  logic [7:0] req_image_col,
   input  logic [2:0] req_image_page,
   input  logic [7:0] req_pixel_byte,
   input  logic       req_set_bits,
   input  logic       req_invert_byte,
   input  logic [7:0] req_page_sel,
   output logic       rsp_strobe,
   output logic       rsp_status,
   output logic [7:0] rsp_read_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int DEPTH  = MAX_COLUMNS * MAX_PAGES;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [7:0]                        width_ff;
   logic [6:0]                        height_ff;
   logic [fbd_pkg::EFF_W_W-1:0]       eff_w;
   logic [fbd_pkg::EFF_P_W-1:0]       eff_p;
   fbd_pkg::req_type                  req;
   logic                              wr_en;
   logic [ADDR_W-1:0]                 wr_addr;
   logic [7:0]                        wr_data;
   logic [ADDR_W-1:0]                 rd_addr;
   logic [7:0]                        rd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= fbd_pkg::WIDTH_RESET;
         height_ff <= fbd_pkg::HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == fbd_pkg::CSR_WIDTH) begin
            width_ff <= csr_wdata;
         end else begin
            height_ff <= csr_wdata[6:0];
         end
      end
   end

   assign eff_w = ({1'b0, width_ff} > fbd_pkg::EFF_W_W'(MAX_COLUMNS)) ?
                  fbd_pkg::EFF_W_W'(MAX_COLUMNS) : {1'b0, width_ff};
   assign eff_p = ({1'b0, height_ff[6:3]} > 5'(MAX_PAGES)) ?
                  fbd_pkg::EFF_P_W'(MAX_PAGES) : height_ff[6:3];

   assign req.op          = req_op;
   assign req.x_first     = req_x_first;
   assign req.x_last      = req_x_last;
   assign req.y_first     = req_y_first;
   assign req.y_last      = req_y_last;
   assign req.image_col   = req_image_col;
   assign req.image_page  = req_image_page;
   assign req.pixel_byte  = req_pixel_byte;
   assign req.set_bits    = req_set_bits;
   assign req.invert_byte = req_invert_byte;
   assign req.page_sel    = req_page_sel;

   fbd_seq #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_PAGES   (MAX_PAGES),
      .DEPTH       (DEPTH),
      .ADDR_W      (ADDR_W)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req           (req),
      .eff_w         (eff_w),
      .eff_p         (eff_p),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_read_data (rsp_read_data),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data)
   );

   fbd_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

### src/fbd_store.sv
// Frame store memory: one write port, one registered read port.
module fbd_store #(
   parameter int DEPTH  = fbd_pkg::DEF_MAX_COLUMNS * fbd_pkg::DEF_MAX_PAGES,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/fbd_seq.sv
// Command sequencer: argument checks, page and column walk, read-modify-write of the store.
module fbd_seq #(
   parameter int MAX_COLUMNS = fbd_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_PAGES   = fbd_pkg::DEF_MAX_PAGES,
   parameter int DEPTH       = MAX_COLUMNS * MAX_PAGES,
   parameter int ADDR_W      = $clog2(DEPTH)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  fbd_pkg::req_type             req,
   input  logic [fbd_pkg::EFF_W_W-1:0]  eff_w,
   input  logic [fbd_pkg::EFF_P_W-1:0]  eff_p,
   output logic                         rsp_strobe,
   output logic                         rsp_status,
   output logic [7:0]                   rsp_read_data,
   output logic                         wr_en,
   output logic [ADDR_W-1:0]            wr_addr,
   output logic [7:0]                   wr_data,
   output logic [ADDR_W-1:0]            rd_addr,
   input  logic [7:0]                   rd_data
);

   localparam int COL_W = $clog2(MAX_COLUMNS);
   localparam int PG_W  = $clog2(MAX_PAGES);
   localparam logic [ADDR_W-1:0] COLS_A = ADDR_W'(MAX_COLUMNS);
   localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(DEPTH - 1);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DECODE = 3'd2;
   localparam logic [2:0] S_IMAGE  = 3'd3;
   localparam logic [2:0] S_WALK   = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   fbd_pkg::req_type  req_ff;

   logic [PG_W-1:0]   pg_ff, pg_in, pg_first_ff, pg_first_in, pg_end_ff, pg_end_in;
   logic [COL_W-1:0]  col_ff, col_in, col_first_ff, col_first_in, col_end_ff, col_end_in;
   logic [7:0]        first_mask_ff, first_mask_in, last_mask_ff, last_mask_in;
   logic              set_ff, set_in, rd_only_ff, rd_only_in;

   logic [8:0]        dw_ff, dw_in;
   logic [5:0]        need_ff, need_in;

   logic              st_vld_ff, st_vld_in;
   logic [ADDR_W-1:0] st_addr_ff, st_addr_in;
   logic [7:0]        st_mask_ff, st_mask_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_status_ff, rsp_status_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;

   logic              accept;
   logic [8:0]        x1_9, x2_9, w_rem;
   logic [7:0]        h8, h_rem, dh;
   logic [8:0]        need_sum;
   logic              x1_oob, x2_oob, y1_oob, y2_oob;
   logic [4:0]        sp, p_rem, tp, tp_next;
   logic [5:0]        dp;
   logic [7:0]        img_b, img_lo, img_hi;
   logic              img_draw, img_two;
   logic [7:0]        walk_mask;
   logic [ADDR_W-1:0] walk_addr;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   assign x1_9   = {1'b0, req_ff.x_first};
   assign x2_9   = {1'b0, req_ff.x_last};
   assign h8     = {1'b0, eff_p, 3'b000};
   assign x1_oob = (x1_9 >= eff_w);
   assign x2_oob = (x2_9 >= eff_w);
   assign y1_oob = (req_ff.y_first >= h8);
   assign y2_oob = (req_ff.y_last >= h8);
   assign w_rem  = eff_w - x1_9;
   assign h_rem  = h8 - req_ff.y_first;
   assign dh     = (req_ff.y_last < h_rem) ? req_ff.y_last : h_rem;
   assign need_sum = {1'b0, dh} + 9'd7;

   assign sp      = req_ff.y_first[7:3];
   assign p_rem   = {1'b0, eff_p} - sp;
   assign dp      = (need_ff < {1'b0, p_rem}) ? need_ff : {1'b0, p_rem};
   assign img_draw = ({1'b0, req_ff.image_col} < dw_ff) && ({3'b000, req_ff.image_page} < dp);
   assign tp      = sp + {2'b00, req_ff.image_page};
   assign tp_next = tp + 5'd1;
   assign img_two = (req_ff.y_first[2:0] != 3'd0) && (tp_next < {1'b0, eff_p});
   assign img_b   = req_ff.invert_byte ? ~req_ff.pixel_byte : req_ff.pixel_byte;
   assign img_lo  = 8'(img_b << req_ff.y_first[2:0]);
   assign img_hi  = 8'(img_b >> (4'd8 - {1'b0, req_ff.y_first[2:0]}));

   always_comb begin
      walk_mask = fbd_pkg::BYTE_ONES;
      if (pg_ff == pg_first_ff) begin
         walk_mask = walk_mask & first_mask_ff;
      end
      if (pg_ff == pg_end_ff) begin
         walk_mask = walk_mask & last_mask_ff;
      end
   end

   assign walk_addr = ADDR_W'(pg_ff) * COLS_A + ADDR_W'(col_ff);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      pg_in         = pg_ff;
      pg_first_in   = pg_first_ff;
      pg_end_in     = pg_end_ff;
      col_in        = col_ff;
      col_first_in  = col_first_ff;
      col_end_in    = col_end_ff;
      first_mask_in = first_mask_ff;
      last_mask_in  = last_mask_ff;
      set_in        = set_ff;
      rd_only_in    = rd_only_ff;
      dw_in         = dw_ff;
      need_in       = need_ff;
      st_vld_in     = 1'b0;
      st_addr_in    = walk_addr;
      st_mask_in    = walk_mask;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rd_addr       = walk_addr;
      wr_en         = st_vld_ff && !rd_only_ff;
      wr_addr       = st_addr_ff;
      wr_data       = set_ff ? (rd_data | st_mask_ff) : (rd_data & ~st_mask_ff);

      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = fbd_pkg::BYTE_ZEROS;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == LAST_A) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            dw_in         = (x2_9 < w_rem) ? x2_9 : w_rem;
            need_in       = need_sum[8:3];
            first_mask_in = fbd_pkg::BYTE_ONES;
            last_mask_in  = fbd_pkg::BYTE_ONES;
            rd_only_in    = 1'b0;
            set_in        = req_ff.set_bits;
            pg_in         = PG_W'(req_ff.y_first[7:3]);
            pg_first_in   = PG_W'(req_ff.y_first[7:3]);
            pg_end_in     = PG_W'(req_ff.y_first[7:3]);
            col_in        = COL_W'(req_ff.x_first);
            col_first_in  = COL_W'(req_ff.x_first);
            col_end_in    = COL_W'(req_ff.x_first);
            rsp_status_in = 1'b0;
            rsp_data_in   = fbd_pkg::BYTE_ZEROS;
            unique case (req_ff.op)
               fbd_pkg::OP_CLEAR, fbd_pkg::OP_FILL: begin
                  set_in       = (req_ff.op == fbd_pkg::OP_FILL);
                  pg_in        = '0;
                  pg_first_in  = '0;
                  pg_end_in    = PG_W'(eff_p - 4'd1);
                  col_in       = '0;
                  col_first_in = '0;
                  col_end_in   = COL_W'(eff_w - 9'd1);
                  if (eff_w == '0 || eff_p == '0) begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end else begin
                     state_in = S_WALK;
                  end
               end
               fbd_pkg::OP_PIXEL: begin
                  first_mask_in = 8'(8'd1 << req_ff.y_first[2:0]);
                  if (x1_oob || y1_oob) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = 1'b1;
                     state_in      = S_IDLE;
                  end else begin
                     state_in = S_WALK;
                  end
               end
               fbd_pkg::OP_RECT: begin
                  pg_end_in     = PG_W'(req_ff.y_last[7:3]);
                  col_end_in    = COL_W'(req_ff.x_last);
                  first_mask_in = 8'(fbd_pkg::BYTE_ONES << req_ff.y_first[2:0]);
                  last_mask_in  = fbd_pkg::BYTE_ONES >> (3'd7 - req_ff.y_last[2:0]);
                  if (x1_oob || x2_oob || y1_oob || y2_oob ||
                      (req_ff.x_first > req_ff.x_last) ||
                      (req_ff.y_first > req_ff.y_last)) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = 1'b1;
                     state_in      = S_IDLE;
                  end else begin
                     state_in = S_WALK;
                  end
               end
               fbd_pkg::OP_IMAGE: begin
                  if ((req_ff.x_last == 8'd0) || (req_ff.y_last == 8'd0) ||
                      x1_oob || y1_oob) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = 1'b1;
                     state_in      = S_IDLE;
                  end else begin
                     state_in = S_IMAGE;
                  end
               end
               fbd_pkg::OP_READ: begin
                  rd_only_in   = 1'b1;
                  pg_in        = PG_W'(req_ff.page_sel);
                  pg_first_in  = PG_W'(req_ff.page_sel);
                  pg_end_in    = PG_W'(req_ff.page_sel);
                  if ((req_ff.page_sel >= {4'd0, eff_p}) || x1_oob) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = 1'b1;
                     state_in      = S_IDLE;
                  end else begin
                     state_in = S_WALK;
                  end
               end
               default: begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = 1'b1;
                  state_in      = S_IDLE;
               end
            endcase
         end
         S_IMAGE: begin
            set_in        = 1'b1;
            col_in        = COL_W'(x1_9 + {1'b0, req_ff.image_col});
            col_first_in  = COL_W'(x1_9 + {1'b0, req_ff.image_col});
            col_end_in    = COL_W'(x1_9 + {1'b0, req_ff.image_col});
            pg_in         = PG_W'(tp);
            pg_first_in   = PG_W'(tp);
            pg_end_in     = img_two ? PG_W'(tp_next) : PG_W'(tp);
            first_mask_in = img_lo;
            last_mask_in  = img_two ? img_hi : fbd_pkg::BYTE_ONES;
            if (img_draw) begin
               state_in = S_WALK;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_WALK: begin
            st_vld_in = 1'b1;
            if (col_ff == col_end_ff) begin
               col_in = col_first_ff;
               if (pg_ff == pg_end_ff) begin
                  state_in = S_FINISH;
               end else begin
                  pg_in = pg_ff + 1'b1;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         S_FINISH: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = 1'b0;
            rsp_data_in   = rd_only_ff ? rd_data : fbd_pkg::BYTE_ZEROS;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         st_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         st_vld_ff    <= st_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req;
      end
      pg_ff         <= pg_in;
      pg_first_ff   <= pg_first_in;
      pg_end_ff     <= pg_end_in;
      col_ff        <= col_in;
      col_first_ff  <= col_first_in;
      col_end_ff    <= col_end_in;
      first_mask_ff <= first_mask_in;
      last_mask_ff  <= last_mask_in;
      set_ff        <= set_in;
      rd_only_ff    <= rd_only_in;
      dw_ff         <= dw_in;
      need_ff       <= need_in;
      st_addr_ff    <= st_addr_in;
      st_mask_ff    <= st_mask_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_strobe    = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_read_data = rsp_data_ff;

endmodule

### src/fbd_checker.sv
// Port-level checks for the page monochrome frame buffer draw block, bound to the top level.
module fbd_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_strobe,
   input logic       rsp_status,
   input logic [7:0] rsp_read_data
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while a command is still in progress");

   a_error_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status) |-> (rsp_read_data == 8'd0))
      else $error("error result carries read data");

endmodule

bind page_mono_framebuffer_draw fbd_checker u_fbd_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_strobe    (rsp_strobe),
   .rsp_status    (rsp_status),
   .rsp_read_data (rsp_read_data)
);

### tb/page_mono_framebuffer_draw_tb.sv
// Self-checking testbench for page_mono_framebuffer_draw against a shadow frame store.
`timescale 1ns / 1ps

module page_mono_framebuffer_draw_tb;

   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam int STORE_DEPTH   = fbd_pkg::DEF_MAX_COLUMNS * fbd_pkg::DEF_MAX_PAGES;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT   = 2_000_000;

   typedef struct {
      logic       status;
      logic [7:0] read_data;
   } draw_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [2:0] req_op = '0;
   logic [7:0] req_x_first = '0;
   logic [7:0] req_x_last = '0;
   logic [7:0] req_y_first = '0;
   logic [7:0] req_y_last = '0;
   logic [7:0] req_image_col = '0;
   logic [2:0] req_image_page = '0;
   logic [7:0] req_pixel_byte = '0;
   logic       req_set_bits = 1'b0;
   logic       req_invert_byte = 1'b0;
   logic [7:0] req_page_sel = '0;
   logic       rsp_strobe;
   logic       rsp_status;
   logic [7:0] rsp_read_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_index = 1'b0;
   logic [7:0] csr_wdata = '0;

   // shadow of the block's state
   logic [7:0] frame_img [STORE_DEPTH];
   logic [7:0] width_reg = fbd_pkg::WIDTH_RESET;
   logic [6:0] height_reg = fbd_pkg::HEIGHT_RESET;

   fbd_pkg::req_type queued_cmds [$];
   draw_result_type  awaited_results [$];
   bit           cmd_beat_taken = 1'b0;
   bit           steady_tail = 1'b0;
   int           hold_cycles = 0;
   int           cycle_count = 0;
   int           fail_count = 0;
   int           op_count [8];
   int           error_status_count = 0;
   int           setting_count = 1;
   logic [7:0]   hot_col = '0;
   logic [7:0]   hot_page = '0;

   page_mono_framebuffer_draw DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_x_first(req_x_first), .req_x_last(req_x_last),
      .req_y_first(req_y_first), .req_y_last(req_y_last),
      .req_image_col(req_image_col), .req_image_page(req_image_page),
      .req_pixel_byte(req_pixel_byte), .req_set_bits(req_set_bits),
      .req_invert_byte(req_invert_byte), .req_page_sel(req_page_sel),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status), .rsp_read_data(rsp_read_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int visible_cols();
      return (width_reg > fbd_pkg::DEF_MAX_COLUMNS) ? fbd_pkg::DEF_MAX_COLUMNS
                                                    : int'(width_reg);
   endfunction

   function automatic int visible_pages();
      int p;
      p = height_reg / 8;
      return (p > fbd_pkg::DEF_MAX_PAGES) ? fbd_pkg::DEF_MAX_PAGES : p;
   endfunction

   function automatic int slot(input int page, input int col);
      return (page * fbd_pkg::DEF_MAX_COLUMNS + col) % STORE_DEPTH;
   endfunction

   task automatic paint(input int idx, input logic [7:0] mask, input logic set);
      if (set) frame_img[idx] = frame_img[idx] | mask;
      else frame_img[idx] = frame_img[idx] & ~mask;
   endtask

   task automatic predict_draw(input fbd_pkg::req_type c, output draw_result_type r);
      int w, p, h, sp, ep, off, dw, dh, dp, tp, col;
      logic [7:0] m, top, bot, b;
      w = visible_cols();
      p = visible_pages();
      h = 8 * p;
      r.status = 1'b0;
      r.read_data = fbd_pkg::BYTE_ZEROS;
      case (c.op)
         fbd_pkg::OP_CLEAR, fbd_pkg::OP_FILL: begin
            for (int pg = 0; pg < p; pg++)
               for (int cl = 0; cl < w; cl++)
                  frame_img[slot(pg, cl)] = (c.op == fbd_pkg::OP_FILL) ?
                                            fbd_pkg::BYTE_ONES : fbd_pkg::BYTE_ZEROS;
         end
         fbd_pkg::OP_PIXEL: begin
            if (c.x_first >= w || c.y_first >= h) r.status = 1'b1;
            else paint(slot(c.y_first / 8, c.x_first), 8'd1 << c.y_first[2:0], c.set_bits);
         end
         fbd_pkg::OP_RECT: begin
            if (c.x_first >= w || c.x_last >= w || c.y_first >= h || c.y_last >= h ||
                c.x_first > c.x_last || c.y_first > c.y_last) begin
               r.status = 1'b1;
            end else begin
               sp = c.y_first / 8;
               ep = c.y_last / 8;
               top = fbd_pkg::BYTE_ONES << c.y_first[2:0];
               bot = fbd_pkg::BYTE_ONES >> (3'd7 - c.y_last[2:0]);
               for (int pg = sp; pg <= ep; pg++) begin
                  m = fbd_pkg::BYTE_ONES;
                  if (pg == sp) m = m & top;
                  if (pg == ep) m = m & bot;
                  for (int cl = c.x_first; cl <= c.x_last; cl++)
                     paint(slot(pg, cl), m, c.set_bits);
               end
            end
         end
         fbd_pkg::OP_IMAGE: begin
            if (c.x_last == 0 || c.y_last == 0 || c.x_first >= w || c.y_first >= h) begin
               r.status = 1'b1;
            end else begin
               dw = (c.x_last < w - c.x_first) ? int'(c.x_last) : w - c.x_first;
               dh = (c.y_last < h - c.y_first) ? int'(c.y_last) : h - c.y_first;
               sp = c.y_first / 8;
               off = c.y_first % 8;
               dp = (dh + 7) / 8;
               if (dp > p - sp) dp = p - sp;
               if (c.image_col < dw && c.image_page < dp) begin
                  b = c.invert_byte ? ~c.pixel_byte : c.pixel_byte;
                  tp = sp + c.image_page;
                  col = c.x_first + c.image_col;
                  m = b << off;
                  paint(slot(tp, col), m, 1'b1);
                  if (off != 0 && tp + 1 < p) begin
                     m = b >> (8 - off);
                     paint(slot(tp + 1, col), m, 1'b1);
                  end
               end
            end
         end
         fbd_pkg::OP_READ: begin
            if (c.page_sel >= p || c.x_first >= w) r.status = 1'b1;
            else r.read_data = frame_img[slot(c.page_sel, c.x_first)];
         end
         default: r.status = 1'b1;
      endcase
   endtask

   function automatic fbd_pkg::req_type cmd(input logic [2:0] op,
                                            input logic [7:0] x1, x2, y1, y2,
                                            input logic [7:0] icol, input logic [2:0] ipage,
                                            input logic [7:0] pbyte, input logic set, inv,
                                            input logic [7:0] psel);
      fbd_pkg::req_type c;
      c.op = op;
      c.x_first = x1;
      c.x_last = x2;
      c.y_first = y1;
      c.y_last = y2;
      c.image_col = icol;
      c.image_page = ipage;
      c.pixel_byte = pbyte;
      c.set_bits = set;
      c.invert_byte = inv;
      c.page_sel = psel;
      return c;
   endfunction

   // mostly inside [0, span), sometimes the boundary, sometimes anywhere
   function automatic logic [7:0] pick(input int span);
      int r;
      r = $urandom_range(0, 19);
      if (span == 0 || r < 2) return 8'($urandom_range(0, 255));
      if (r == 2) return 8'(span);
      return 8'($urandom_range(0, span - 1));
   endfunction

   function automatic fbd_pkg::req_type random_draw();
      fbd_pkg::req_type c;
      int w, p, h, r, lim;
      w = visible_cols();
      p = visible_pages();
      h = 8 * p;
      c = {$urandom, $urandom};
      r = $urandom_range(0, 99);
      if (r < 1) c.op = fbd_pkg::OP_CLEAR;
      else if (r < 3) c.op = fbd_pkg::OP_FILL;
      else if (r < 5) c.op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
      else if (r < 25) c.op = fbd_pkg::OP_PIXEL;
      else if (r < 40) c.op = fbd_pkg::OP_RECT;
      else if (r < 65) c.op = fbd_pkg::OP_IMAGE;
      else c.op = fbd_pkg::OP_READ;
      case (c.op)
         fbd_pkg::OP_PIXEL: begin
            if (w > 0 && p > 0 && hot_col < w && hot_page < p && $urandom_range(0, 1)) begin
               c.x_first = hot_col;
               c.y_first = 8'(hot_page * 8 + $urandom_range(0, 7));
            end else begin
               c.x_first = pick(w);
               c.y_first = pick(h);
            end
         end
         fbd_pkg::OP_RECT: begin
            if (w > 0 && p > 0 && $urandom_range(0, 9) != 0) begin
               c.x_first = 8'($urandom_range(0, w - 1));
               lim = ($urandom_range(0, 19) == 0) ? w : 8;
               c.x_last = c.x_first + 8'($urandom_range(0, lim - 1));
               if (c.x_last >= w) c.x_last = 8'(w - 1);
               c.y_first = 8'($urandom_range(0, h - 1));
               lim = ($urandom_range(0, 19) == 0) ? h : 16;
               c.y_last = c.y_first + 8'($urandom_range(0, lim - 1));
               if (c.y_last >= h) c.y_last = 8'(h - 1);
               if ($urandom_range(0, 9) == 0) {c.x_first, c.x_last} = {c.x_last, c.x_first};
               if ($urandom_range(0, 9) == 0) {c.y_first, c.y_last} = {c.y_last, c.y_first};
               hot_col = c.x_first;
               hot_page = c.y_first / 8;
            end else begin
               c.x_first = pick(w);
               c.x_last = pick(w);
               c.y_first = pick(h);
               c.y_last = pick(h);
            end
         end
         fbd_pkg::OP_IMAGE: begin
            c.x_first = pick(w);
            c.y_first = pick(h);
            r = $urandom_range(0, 19);
            c.x_last = (r == 0) ? 8'd0 : (r == 1) ? 8'($urandom) : 8'($urandom_range(1, 12));
            r = $urandom_range(0, 19);
            c.y_last = (r == 0) ? 8'd0 : (r == 1) ? 8'($urandom) : 8'($urandom_range(1, 20));
            if ($urandom_range(0, 9) != 0) c.image_col = 8'($urandom_range(0, c.x_last));
            if ($urandom_range(0, 4) != 0) c.image_page = 3'($urandom_range(0, 3));
            if (c.x_first < w && c.y_first < h) begin
               hot_col = c.x_first + c.image_col;
               hot_page = c.y_first / 8 + c.image_page;
            end
         end
         fbd_pkg::OP_READ: begin
            if ($urandom_range(0, 9) < 6) begin
               c.x_first = hot_col + 8'($urandom_range(0, 3));
               c.page_sel = hot_page + 8'($urandom_range(0, 1));
            end else begin
               c.x_first = pick(w);
               c.page_sel = pick(p);
            end
         end
         default: ;
      endcase
      return c;
   endfunction

   task automatic write_reg(input logic idx, input logic [7:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == fbd_pkg::CSR_WIDTH) width_reg = value;
      else height_reg = value[6:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic settle();
      while (queued_cmds.size() != 0 || start || awaited_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_random(input int n);
      repeat (n) queued_cmds.push_back(random_draw());
      settle();
   endtask

   task automatic new_setting(input logic [7:0] w, input logic [7:0] h);
      write_reg(fbd_pkg::CSR_WIDTH, w);
      write_reg(fbd_pkg::CSR_HEIGHT, h);
      setting_count++;
   endtask

   // command driver
   always @(negedge clock) begin
      fbd_pkg::req_type c;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || cmd_beat_taken) begin
         cmd_beat_taken = 1'b0;
         if (hold_cycles > 0) begin
            hold_cycles--;
            start <= 1'b0;
         end else if (queued_cmds.size() != 0 && !steady_tail && $urandom_range(0, 7) == 0) begin
            hold_cycles = $urandom_range(0, 6);
            start <= 1'b0;
         end else if (queued_cmds.size() != 0) begin
            c = queued_cmds.pop_front();
            start <= 1'b1;
            req_op <= c.op;
            req_x_first <= c.x_first;
            req_x_last <= c.x_last;
            req_y_first <= c.y_first;
            req_y_last <= c.y_last;
            req_image_col <= c.image_col;
            req_image_page <= c.image_page;
            req_pixel_byte <= c.pixel_byte;
            req_set_bits <= c.set_bits;
            req_invert_byte <= c.invert_byte;
            req_page_sel <= c.page_sel;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: check result beats, predict accepted command beats
   always @(posedge clock) begin
      fbd_pkg::req_type c;
      draw_result_type  want, got;
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results outstanding", $time, awaited_results.size());
         $display("TB_ERROR");
         $finish;
      end else if (!reset) begin
         if (rsp_strobe) begin
            got.status = rsp_status;
            got.read_data = rsp_read_data;
            if (awaited_results.size() == 0) begin
               fail_count++;
               $display("%0t: result beat expected none actual status %0d read_data %02h",
                        $time, got.status, got.read_data);
            end else begin
               want = awaited_results.pop_front();
               if (got.status !== want.status) begin
                  fail_count++;
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, got.status);
               end
               if (got.read_data !== want.read_data) begin
                  fail_count++;
                  $display("%0t: read_data expected %02h actual %02h",
                           $time, want.read_data, got.read_data);
               end
            end
         end
         if (start && !busy) begin
            c = cmd(req_op, req_x_first, req_x_last, req_y_first, req_y_last, req_image_col,
                    req_image_page, req_pixel_byte, req_set_bits, req_invert_byte,
                    req_page_sel);
            predict_draw(c, want);
            awaited_results.push_back(want);
            op_count[c.op]++;
            if (want.status) error_status_count++;
            cmd_beat_taken = 1'b1;
         end
      end
   end

   initial begin
      foreach (frame_img[i]) frame_img[i] = fbd_pkg::BYTE_ZEROS;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed pass at reset setting, 128 by 64
      queued_cmds.push_back(cmd(fbd_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      queued_cmds.push_back(cmd(fbd_pkg::OP_READ, 127, 0, 0, 0, 0, 0, 0, 0, 0, 7));
      queued_cmds.push_back(cmd(fbd_pkg::OP_FILL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      queued_cmds.push_back(cmd(fbd_pkg::OP_READ, 127, 0, 0, 0, 0, 0, 0, 0, 0, 7));
      queued_cmds.push_back(cmd(fbd_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      queued_cmds.push_back(cmd(fbd_pkg::OP_PIXEL, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
      queued_cmds.push_back(cmd(fbd_pkg::OP_PIXEL, 127, 0, 63, 0, 0, 0, 0, 1, 0, 0));
      queued_cmds.push_back(cmd(fbd_pkg::OP_READ, 127, 0, 0, 0, 0, 0, 0, 0, 0, 7));
      queued_cmds.push_back(cmd(fbd_pkg::OP_PIXEL, 127, 0, 63, 0, 0, 0, 0, 0, 0, 0));
      queued_cmds.push_back(cmd(fbd_pkg::OP_PIXEL, 128, 0, 0, 0, 0, 0, 0, 1, 0, 0));
      queued_cmds.push_back(cmd(fbd_pkg::OP_PIXEL, 0, 0, 64, 0, 0, 0, 0, 1, 0, 0));
      queued_cmds.push_back(cmd(fbd_pkg::OP_RECT, 3, 10, 5, 20, 0, 0, 0, 1, 0, 0));
      queued_cmds.push_back(cmd(fbd_pkg::OP_RECT, 10, 3, 5, 20, 0, 0, 0, 1, 0, 0));
      queued_cmds.push_back(cmd(fbd_pkg::OP_RECT, 3, 10, 20, 5, 0, 0, 0, 1, 0, 0));
      queued_cmds.push_back(cmd(fbd_pkg::OP_RECT, 3, 128, 5, 20, 0, 0, 0, 1, 0, 0));
      queued_cmds.push_back(cmd(fbd_pkg::OP_RECT, 4, 6, 9, 9, 0, 0, 0, 0, 0, 0));
      queued_cmds.push_back(cmd(fbd_pkg::OP_IMAGE, 10, 4, 3, 10, 0, 0, 8'hA5, 0, 0, 0));
      queued_cmds.push_back(cmd(fbd_pkg::OP_IMAGE, 10, 4, 3, 10, 0, 1, 8'hA5, 0, 1, 0));
      queued_cmds.push_back(cmd(fbd_pkg::OP_IMAGE, 10, 4, 3, 10, 4, 0, 8'hFF, 0, 0, 0));
      queued_cmds.push_back(cmd(fbd_pkg::OP_IMAGE, 10, 0, 3, 10, 0, 0, 8'hFF, 0, 0, 0));
      queued_cmds.push_back(cmd(fbd_pkg::OP_IMAGE, 10, 4, 3, 0, 0, 0, 8'hFF, 0, 0, 0));
      queued_cmds.push_back(cmd(fbd_pkg::OP_IMAGE, 50, 2, 60, 8, 1, 0, 8'hFF, 0, 0, 0));
      queued_cmds.push_back(cmd(fbd_pkg::OP_IMAGE, 255, 4, 3, 10, 0, 0, 8'hFF, 0, 0, 0));
      queued_cmds.push_back(cmd(fbd_pkg::OP_READ, 51, 0, 0, 0, 0, 0, 0, 0, 0, 7));
      queued_cmds.push_back(cmd(fbd_pkg::OP_READ, 10, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      queued_cmds.push_back(cmd(fbd_pkg::OP_READ, 10, 0, 0, 0, 0, 0, 0, 0, 0, 1));
      queued_cmds.push_back(cmd(fbd_pkg::OP_READ, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      queued_cmds.push_back(cmd(fbd_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 8));
      queued_cmds.push_back(cmd(fbd_pkg::OP_READ, 200, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      queued_cmds.push_back(cmd(OP_SPARE_LO, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      queued_cmds.push_back(cmd(OP_SPARE_HI, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      settle();

      new_setting(8'd1, 8'd16);
      run_random(150);
      new_setting(8'd255, 8'hFF);
      run_random(300);
      new_setting(8'd77, 8'hAB);
      run_random(300);
      new_setting(8'd0, 8'd7);
      run_random(40);
      new_setting(8'd128, 8'd64);
      run_random(400);
      new_setting(8'd200, 8'h38);
      run_random(300);
      steady_tail = 1'b1;
      run_random(200);

      $display("Ran %0d commands over %0d register settings: clear %0d, fill %0d, pixel %0d,",
               op_count.sum(), setting_count, op_count[fbd_pkg::OP_CLEAR],
               op_count[fbd_pkg::OP_FILL], op_count[fbd_pkg::OP_PIXEL]);
      $display("rectangle %0d, image %0d, read %0d, unused op %0d; %0d answered with error",
               op_count[fbd_pkg::OP_RECT], op_count[fbd_pkg::OP_IMAGE],
               op_count[fbd_pkg::OP_READ], op_count[OP_SPARE_LO] + op_count[OP_SPARE_HI],
               error_status_count);
      if (fail_count == 0 && awaited_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### files.f
src/fbd_pkg.sv
src/fbd_store.sv
src/fbd_seq.sv
src/page_mono_framebuffer_draw.sv
src/fbd_checker.sv
tb/page_mono_framebuffer_draw_tb.sv
